// ===== src/rpam_pkg.sv =====
`default_nettype none
package rpam_pkg;

  localparam int VW = 30;            // vector lane width, 24 fraction bits
  localparam int ZW = 28;            // angle accumulator, 1/2^24 turn
  localparam int QB = 20;            // density quotient bits
  localparam int NUMW = 44;          // density numerator width
  localparam int DENW = 33;          // density denominator width
  localparam int SYW = 26;           // bits of the sine lane used
  localparam int RCPW = 36;          // reciprocal width for sector centre
  localparam int RSH = 13;           // reciprocal scale beyond 2^23

  localparam int ANG_FULL = 16777216;
  localparam int ANG_HALF = 8388608;
  localparam int ANG_QUARTER = 4194304;
  localparam int ONE_Q24 = 16777216;
  localparam int INV_GAIN = 10188014;

  localparam logic [2:0] REG_BLADES = 3'd0;
  localparam logic [2:0] REG_ROT = 3'd1;
  localparam logic [2:0] REG_RED = 3'd2;
  localparam logic [2:0] REG_GREEN = 3'd3;
  localparam logic [2:0] REG_BLUE = 3'd4;

  localparam logic [23:0] ATAN_TAB [0:23] = '{
    24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669, 24'd83416,
    24'd41718, 24'd20860, 24'd10430, 24'd5215, 24'd2608, 24'd1304,
    24'd652, 24'd326, 24'd163, 24'd81, 24'd41, 24'd20,
    24'd10, 24'd5, 24'd3, 24'd1, 24'd1, 24'd0
  };

  typedef struct packed {
    logic [16:0] coord_u;
    logic [16:0] coord_v;
  } req_t;

  typedef struct packed {
    logic        inside_res;
    logic [31:0] out_red;
    logic [31:0] out_green;
    logic [31:0] out_blue;
    logic [31:0] density;
  } res_t;

  typedef struct packed {
    logic valid;
    logic origin;
  } tag_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
  } point_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  typedef struct packed {
    tag_t   tag;
    point_t orig;
    vec_t   v;
  } vec_bus_t;

  typedef struct packed {
    tag_t tag;
    vec_t pt;
    vec_t rf;
    vec_t sn;
  } rot_bus_t;

  typedef struct packed {
    tag_t            tag;
    logic            hit;
    logic            sflag;
    logic [DENW-1:0] den;
    logic [NUMW-1:0] rem;
    logic [QB-1:0]   quo;
  } div_bus_t;

  function automatic logic signed [ZW-1:0] atan_z(input int i);
    logic signed [ZW-1:0] a;
    a = $signed({{(ZW-24){1'b0}}, ATAN_TAB[i]});
    return a;
  endfunction

  function automatic vec_t vec_step(input vec_t v, input int i);
    logic signed [VW-1:0] dx, dy;
    vec_t o;
    dx = v.y >>> i;
    dy = v.x >>> i;
    o = v;
    if (v.y >= 0) begin
      o.x = v.x + dx;
      o.y = v.y - dy;
      o.z = v.z + atan_z(i);
    end else begin
      o.x = v.x - dx;
      o.y = v.y + dy;
      o.z = v.z - atan_z(i);
    end
    return o;
  endfunction

  function automatic vec_t rot_step(input vec_t v, input int i);
    logic signed [VW-1:0] dx, dy;
    vec_t o;
    dx = v.y >>> i;
    dy = v.x >>> i;
    o = v;
    if (v.z >= 0) begin
      o.x = v.x - dx;
      o.y = v.y + dy;
      o.z = v.z - atan_z(i);
    end else begin
      o.x = v.x + dx;
      o.y = v.y - dy;
      o.z = v.z + atan_z(i);
    end
    return o;
  endfunction

  // bring the angle into [-quarter, quarter] turn before the rotation stages
  function automatic vec_t rot_fold(input logic signed [VW-1:0] x,
                                    input logic signed [VW-1:0] y,
                                    input logic [23:0] ang);
    vec_t o;
    o.x = x;
    o.y = y;
    o.z = $signed({{(ZW-24){1'b0}}, ang});
    if (ang[23]) begin
      o.z = o.z - ZW'(ANG_FULL);
    end
    if (o.z > ZW'(ANG_QUARTER)) begin
      o.x = -x;
      o.y = -y;
      o.z = o.z - ZW'(ANG_HALF);
    end else if (o.z < -ZW'(ANG_QUARTER)) begin
      o.x = -x;
      o.y = -y;
      o.z = o.z + ZW'(ANG_HALF);
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== src/rpam_vec_cell.sv =====
`default_nettype none
module rpam_vec_cell import rpam_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic     clk,
  input  logic     rst,
  input  vec_bus_t din,
  output vec_bus_t dout
);

  vec_bus_t dout_next;

  always_comb begin
    dout_next = din;
    dout_next.v = vec_step(din.v, STAGE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else begin
      dout <= dout_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/rpam_rot_cell.sv =====
`default_nettype none
module rpam_rot_cell import rpam_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic     clk,
  input  logic     rst,
  input  rot_bus_t din,
  output rot_bus_t dout
);

  // point, edge reference and sine reference share the same stage
  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else begin
      dout.tag <= din.tag;
      dout.pt <= rot_step(din.pt, STAGE);
      dout.rf <= rot_step(din.rf, STAGE);
      dout.sn <= rot_step(din.sn, STAGE);
    end
  end

endmodule
`default_nettype wire

// ===== src/rpam_div_cell.sv =====
`default_nettype none
module rpam_div_cell import rpam_pkg::*; #(
  parameter int QBIT = 0
) (
  input  logic     clk,
  input  logic     rst,
  input  div_bus_t din,
  output div_bus_t dout
);

  logic [63:0] trial;
  logic [63:0] rem_w;
  div_bus_t    dout_next;

  assign trial = 64'(din.den) << QBIT;
  assign rem_w = 64'(din.rem);

  always_comb begin
    dout_next = din;
    if (rem_w >= trial) begin
      dout_next.rem = din.rem - trial[NUMW-1:0];
      dout_next.quo[QBIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else begin
      dout <= dout_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/regular_polygon_aperture_mask.sv =====
`default_nettype none
// Regular polygon aperture mask: tests a texture coordinate against an
// N-sided polygon of corner radius 1 and returns mask values.
// Request channel: a coordinate pair on req is taken at a clock edge with
// start high and busy low. busy stays low, so one request per cycle is taken.
// Result channel: done is high for one cycle with result holding inside_res,
// the three channel values (or zero) and the density 1/area (or zero).
// The receiver cannot stall; results leave in request order.
// Path: entry register, vectoring CORDIC cells, sector index and sector
// centre registers, rotation entry register, rotation CORDIC cells, edge test
// register, the 20-cell restoring divider for the density, result register.
// Throughput: one per cycle.
// Configuration: APB writes at byte address 4*index (blade count, rotation,
// red, green, blue). Write only while no request is in flight.
// Reset (synchronous) loads 6 blades, rotation 2731 and values of 1.0, and
// empties the pipeline; no results appear until new requests arrive.
module regular_polygon_aperture_mask import rpam_pkg::*; #(
  parameter int MAX_BLADES = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  req_t        req,
  output logic        busy,
  output logic        done,
  output res_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NW = $clog2(MAX_BLADES + 1);

  logic [4:0]  blade_count;
  logic [15:0] rotation_angle;
  logic [31:0] value_red;
  logic [31:0] value_green;
  logic [31:0] value_blue;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign busy = 1'b0;
  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      blade_count <= 5'd6;
      rotation_angle <= 16'd2731;
      value_red <= 32'd65536;
      value_green <= 32'd65536;
      value_blue <= 32'd65536;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BLADES: blade_count <= pwdata[4:0];
        REG_ROT:    rotation_angle <= pwdata[15:0];
        REG_RED:    value_red <= pwdata;
        REG_GREEN:  value_green <= pwdata;
        REG_BLUE:   value_blue <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLADES: prdata = {27'd0, blade_count};
      REG_ROT:    prdata = {16'd0, rotation_angle};
      REG_RED:    prdata = value_red;
      REG_GREEN:  prdata = value_green;
      REG_BLUE:   prdata = value_blue;
      default:    prdata = '0;
    endcase
  end

  // clamped blade count
  logic [NW-1:0] nc;
  always_comb begin
    if (blade_count < 5'd3) begin
      nc = NW'(3);
    end else if ({27'd0, blade_count} > MAX_BLADES) begin
      nc = NW'(MAX_BLADES);
    end else begin
      nc = NW'(blade_count);
    end
  end

  // per blade count constants
  logic [RCPW-1:0] recip_tab [0:MAX_BLADES];
  logic [23:0]     half_tab [0:MAX_BLADES];
  logic [23:0]     full_tab [0:MAX_BLADES];

  for (genvar g = 0; g <= MAX_BLADES; g++) begin : g_tab
    localparam longint unsigned GD = (g < 3) ? 3 : g;
    localparam longint unsigned RCP = ((64'd1 << RCPW) + GD - 1) / GD;
    localparam longint unsigned HALF = 64'd8388608 / GD;
    localparam longint unsigned FULL = 64'd16777216 / GD;
    assign recip_tab[g] = RCP[RCPW-1:0];
    assign half_tab[g] = HALF[23:0];
    assign full_tab[g] = FULL[23:0];
  end

  logic [23:0] rot24;
  assign rot24 = {rotation_angle, 8'd0};

  // entry: map to [-1,3), fold into the right half plane
  vec_bus_t vbus [0:CORDIC_STAGES];
  logic signed [VW-1:0] ex, ey;

  assign ex = $signed({4'd0, req.coord_u, 9'd0}) - VW'(ONE_Q24);
  assign ey = $signed({4'd0, req.coord_v, 9'd0}) - VW'(ONE_Q24);

  always_ff @(posedge clk) begin
    if (rst) begin
      vbus[0] <= '0;
    end else begin
      vbus[0].tag.valid <= start;
      vbus[0].tag.origin <= (req.coord_u == 17'd0) && (req.coord_v == 17'd0);
      vbus[0].orig.x <= ex;
      vbus[0].orig.y <= ey;
      if (ex < 0) begin
        vbus[0].v.x <= -ex;
        vbus[0].v.y <= -ey;
        vbus[0].v.z <= ZW'(ANG_HALF);
      end else begin
        vbus[0].v.x <= ex;
        vbus[0].v.y <= ey;
        vbus[0].v.z <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    rpam_vec_cell #(.STAGE(i)) u_cell (
      .clk (clk),
      .rst (rst),
      .din (vbus[i]),
      .dout(vbus[i+1])
    );
  end

  // sector index
  logic [23:0]      phi;
  logic [24+NW-1:0] kprod;
  tag_t             a_tag;
  point_t           a_pt;
  logic [NW-1:0]    a_k;

  assign phi = vbus[CORDIC_STAGES].v.z[23:0] - rot24;
  assign kprod = phi * nc;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag <= '0;
    end else begin
      a_tag <= vbus[CORDIC_STAGES].tag;
    end
  end

  always_ff @(posedge clk) begin
    a_pt <= vbus[CORDIC_STAGES].orig;
    a_k <= kprod[24+NW-1:24];
  end

  // sector center offset floor((2k+1)*2^23/n) by reciprocal
  logic [NW+RCPW:0] cprod;
  tag_t             b_tag;
  point_t           b_pt;
  logic [23:0]      b_off;

  assign cprod = {a_k, 1'b1} * recip_tab[nc];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_tag <= '0;
    end else begin
      b_tag <= a_tag;
    end
  end

  always_ff @(posedge clk) begin
    b_pt <= a_pt;
    b_off <= cprod[RSH+23:RSH];
  end

  // rotation entry
  rot_bus_t    rbus [0:CORDIC_STAGES];
  logic [23:0] rang;

  assign rang = 24'd0 - (rot24 + b_off);

  always_ff @(posedge clk) begin
    if (rst) begin
      rbus[0] <= '0;
    end else begin
      rbus[0].tag <= b_tag;
      rbus[0].pt <= rot_fold(b_pt.x, b_pt.y, rang);
      rbus[0].rf <= rot_fold(VW'(ONE_Q24), '0, half_tab[nc]);
      rbus[0].sn <= rot_fold(VW'(INV_GAIN), '0, full_tab[nc]);
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    rpam_rot_cell #(.STAGE(i)) u_cell (
      .clk (clk),
      .rst (rst),
      .din (rbus[i]),
      .dout(rbus[i+1])
    );
  end

  // edge test and density denominator
  div_bus_t        dbus [0:QB];
  logic [DENW-1:0] den_c;
  rot_bus_t        rlast;

  assign rlast = rbus[CORDIC_STAGES];
  assign den_c = DENW'(rlast.sn.y[SYW-1:0]) * DENW'(nc);

  always_ff @(posedge clk) begin
    if (rst) begin
      dbus[0] <= '0;
    end else begin
      dbus[0].tag <= rlast.tag;
      dbus[0].hit <= rlast.tag.origin || (rlast.pt.x <= rlast.rf.x);
      dbus[0].sflag <= rlast.sn.y > 0;
      dbus[0].den <= den_c;
      dbus[0].rem <= (NUMW'(1) << 43) + NUMW'(den_c >> 1);
      dbus[0].quo <= '0;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    rpam_div_cell #(.QBIT(QB - 1 - i)) u_cell (
      .clk (clk),
      .rst (rst),
      .din (dbus[i]),
      .dout(dbus[i+1])
    );
  end

  // result register
  div_bus_t dlast;
  assign dlast = dbus[QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dlast.tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    result.inside_res <= dlast.hit;
    result.out_red <= dlast.hit ? value_red : 32'd0;
    result.out_green <= dlast.hit ? value_green : 32'd0;
    result.out_blue <= dlast.hit ? value_blue : 32'd0;
    result.density <= (dlast.hit && dlast.sflag) ? 32'(dlast.quo) : 32'd0;
  end

endmodule
`default_nettype wire

// ===== verif/regular_polygon_aperture_mask_tb.sv =====
module regular_polygon_aperture_mask_tb;
  import rpam_pkg::*;

  localparam int STAGES = 16;
  localparam int BLADES_MAX = 16;
  localparam longint ANG_MASK = 64'hFF_FFFF;
  localparam int LATENCY = 2 * STAGES + 26;
  localparam int STALL_LIMIT = 5000;
  localparam logic [2:0] REG_UNUSED = 3'd5;

  logic        clk;
  logic        rst;
  logic        start;
  req_t        req;
  logic        busy;
  logic        done;
  res_t        result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  regular_polygon_aperture_mask u_dut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the mask registers
  logic [4:0]  sides_q;
  logic [15:0] spin_q;
  logic [31:0] red_q;
  logic [31:0] green_q;
  logic [31:0] blue_q;

  req_t pending_coords[$];
  res_t expected_masks[$];
  int   gap_left;
  bit   no_gaps;
  bit   hold_requests;
  bit   took;
  int   quiet_cycles;
  int   errors;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void cordic_turn(inout longint x, inout longint y, input longint ang);
    longint z, dx, dy;
    z = ang & ANG_MASK;
    if (z >= ANG_HALF) z -= ANG_FULL;
    if (z > ANG_QUARTER) begin
      x = -x; y = -y; z -= ANG_HALF;
    end else if (z < -ANG_QUARTER) begin
      x = -x; y = -y; z += ANG_HALF;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
  endfunction

  function automatic longint polar_angle(input longint x0, input longint y0);
    longint x, y, z, dx, dy;
    x = x0; y = y0; z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = ANG_HALF;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end
    end
    return z & ANG_MASK;
  endfunction

  function automatic res_t predict_mask(input req_t c);
    longint n, x, y, rot, theta, phi, k, centre, rx, ry, sx, sy, den, dens;
    bit in_poly;
    res_t r;
    n = sides_q;
    if (n < 3) n = 3;
    if (n > BLADES_MAX) n = BLADES_MAX;
    if (c.coord_u == 0 && c.coord_v == 0) begin
      in_poly = 1'b1;
    end else begin
      x = (longint'(c.coord_u) * 2 - 65536) * 256;
      y = (longint'(c.coord_v) * 2 - 65536) * 256;
      rot = longint'(spin_q) << 8;
      theta = polar_angle(x, y);
      phi = (theta - rot) & ANG_MASK;
      k = (phi * n) >> 24;
      centre = (rot + (((2 * k + 1) << 23) / n)) & ANG_MASK;
      rx = ONE_Q24;
      ry = 0;
      cordic_turn(x, y, (ANG_FULL - centre) & ANG_MASK);
      cordic_turn(rx, ry, ANG_HALF / n);
      in_poly = x <= rx;
    end
    r = '0;
    if (in_poly) begin
      sx = INV_GAIN;
      sy = 0;
      dens = 0;
      cordic_turn(sx, sy, ANG_FULL / n);
      if (sy > 0) begin
        den = sy * n;
        dens = ((longint'(1) << 43) + den / 2) / den;
      end
      r.inside_res = 1'b1;
      r.out_red = red_q;
      r.out_green = green_q;
      r.out_blue = blue_q;
      r.density = dens[31:0];
    end
    return r;
  endfunction

  // driver: requests change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      req <= '0;
      gap_left = 0;
    end else begin
      if (took) begin
        void'(pending_coords.pop_front());
        gap_left = no_gaps ? 0 : $urandom_range(0, 7);
      end
      if (gap_left > 0 || pending_coords.size() == 0 || hold_requests) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        start <= 1'b1;
        req <= pending_coords[0];
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      took = 1'b0;
      quiet_cycles = 0;
    end else begin
      res_t exp_r;
      took = start && !busy;
      if (took) expected_masks.push_back(predict_mask(req));
      if (done) begin
        if (expected_masks.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          errors++;
        end else begin
          exp_r = expected_masks.pop_front();
          if (result.inside_res !== exp_r.inside_res) begin
            $display("%0t: inside_res exp %h got %h", $time, exp_r.inside_res,
                     result.inside_res);
            errors++;
          end
          if (result.out_red !== exp_r.out_red) begin
            $display("%0t: out_red exp %h got %h", $time, exp_r.out_red, result.out_red);
            errors++;
          end
          if (result.out_green !== exp_r.out_green) begin
            $display("%0t: out_green exp %h got %h", $time, exp_r.out_green,
                     result.out_green);
            errors++;
          end
          if (result.out_blue !== exp_r.out_blue) begin
            $display("%0t: out_blue exp %h got %h", $time, exp_r.out_blue, result.out_blue);
            errors++;
          end
          if (result.density !== exp_r.density) begin
            $display("%0t: density exp %h got %h", $time, exp_r.density, result.density);
            errors++;
          end
        end
      end
      if (took || done) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic apb_write(input logic [2:0] index, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_BLADES: sides_q = data[4:0];
      REG_ROT:    spin_q = data[15:0];
      REG_RED:    red_q = data;
      REG_GREEN:  green_q = data;
      REG_BLUE:   blue_q = data;
      default:    ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_coords.size() != 0 || expected_masks.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic push_coord(input logic [16:0] u, input logic [16:0] v);
    req_t c;
    c.coord_u = u;
    c.coord_v = v;
    pending_coords.push_back(c);
  endtask

  task automatic push_random(input int count);
    logic [16:0] u, v;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        u = 17'($urandom_range(0, 131071));
        v = 17'($urandom_range(0, 131071));
      end else begin
        u = 17'($urandom_range(0, 65536));
        v = 17'($urandom_range(0, 65536));
      end
      push_coord(u, v);
    end
  endtask

  logic [4:0]  sides_set [0:8] = '{5'd3, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd4, 5'd8, 5'd5};

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    no_gaps = 1'b0;
    hold_requests = 1'b0;
    sides_q = 5'd6;
    spin_q = 16'd2731;
    red_q = 32'h10000;
    green_q = 32'h10000;
    blue_q = 32'h10000;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed corners and special points at reset settings
    push_coord(17'd0, 17'd0);
    push_coord(17'd65536, 17'd65536);
    push_coord(17'd0, 17'd65536);
    push_coord(17'd65536, 17'd0);
    push_coord(17'd32768, 17'd32768);
    push_coord(17'd131071, 17'd131071);
    push_coord(17'd131071, 17'd0);
    push_coord(17'd0, 17'd131071);
    push_coord(17'd1, 17'd0);
    push_coord(17'd0, 17'd1);
    push_coord(17'd32768, 17'd0);
    push_coord(17'd65536, 17'd32768);
    push_coord(17'd32768, 17'd65536);
    push_coord(17'd0, 17'd32768);
    push_coord(17'd32769, 17'd32767);
    push_coord(17'd98304, 17'd16384);
    push_coord(17'h15555, 17'h0AAAA);
    push_random(180);

    // sender holds until the pipeline drains
    while (pending_coords.size() > 100) @(posedge clk);
    hold_requests = 1'b1;
    while (expected_masks.size() != 0) @(posedge clk);
    hold_requests = 1'b0;
    wait_idle();

    // write beyond the register list is dropped
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);

    for (int p = 0; p < 9; p++) begin
      apb_write(REG_BLADES, {27'd0, sides_set[p]});
      case (p % 3)
        0: apb_write(REG_ROT, 32'd0);
        1: apb_write(REG_ROT, 32'h0000_FFFF);
        default: apb_write(REG_ROT, $urandom);
      endcase
      case (p % 4)
        0: begin
          apb_write(REG_RED, 32'hFFFF_FFFF);
          apb_write(REG_GREEN, 32'd0);
          apb_write(REG_BLUE, 32'hFFFF_FFFF);
        end
        1: begin
          apb_write(REG_RED, 32'd0);
          apb_write(REG_GREEN, 32'hFFFF_FFFF);
          apb_write(REG_BLUE, 32'd0);
        end
        default: begin
          apb_write(REG_RED, $urandom);
          apb_write(REG_GREEN, $urandom);
          apb_write(REG_BLUE, $urandom);
        end
      endcase
      no_gaps = (p % 3 == 1);
      push_coord(17'd0, 17'd0);
      push_coord(17'd32768, 17'd32768);
      push_random(180);
      wait_idle();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rpam_pkg.sv
src/rpam_vec_cell.sv
src/rpam_rot_cell.sv
src/rpam_div_cell.sv
src/regular_polygon_aperture_mask.sv
verif/regular_polygon_aperture_mask_tb.sv
